FILE: src/ftng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftng_pkg
// shared types and constants of the flat triangle normal generator
// ----------------------------------------------------------------------------
package ftng_pkg;

  localparam int POS_W     = 32;
  localparam int NRM_W     = 16;
  localparam int NFRAC     = 14;
  localparam int CNT_W     = 6;
  localparam int MUL_STEPS = 6;
  localparam int SQ_STEPS  = 3;
  localparam int SQRT_ITER = 32;
  localparam int Q_W       = 17;
  localparam int DIV_LAST  = Q_W + 1;

  localparam logic signed [NRM_W-1:0] NORM_LIM = NRM_W'(1 << NFRAC);

  localparam logic CFG_FLIP = 1'b0;
  localparam logic CFG_CALC = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_LOAD_A = 12'b0000_0000_0010,
    S_NORM_A = 12'b0000_0000_0100,
    S_LOAD_B = 12'b0000_0000_1000,
    S_NORM_B = 12'b0000_0001_0000,
    S_MUL    = 12'b0000_0010_0000,
    S_CHK    = 12'b0000_0100_0000,
    S_NORM_C = 12'b0000_1000_0000,
    S_SQ     = 12'b0001_0000_0000,
    S_SQRT   = 12'b0010_0000_0000,
    S_DIV    = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             load_a;
    logic             load_b;
    logic             save_a;
    logic             save_b;
    logic             norm_step;
    logic             mul;
    logic             load_c;
    logic             set_degen;
    logic             sq;
    logic             sqrt;
    logic             div;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
  } cmd_t;

  typedef struct packed {
    logic third;
    logic calc;
    logic norm_done;
    logic c_zero;
  } status_t;

endpackage

FILE: src/ftng_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftng_ctrl
// sequencer: vertex collection, face normal steps and corner emission
// ----------------------------------------------------------------------------
module ftng_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  ftng_pkg::status_t sts,
  output ftng_pkg::cmd_t   cmd
);
  import ftng_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       comp_r, comp_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    cmd.comp  = comp_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          comp_nxt   = 2'd0;
          cnt_nxt    = '0;
          if (sts.third) begin
            state_nxt = sts.calc ? S_LOAD_A : S_EMIT;
          end
        end
      end
      S_LOAD_A: begin
        cmd.load_a = 1'b1;
        state_nxt  = S_NORM_A;
      end
      S_NORM_A: begin
        if (sts.norm_done) begin
          cmd.save_a = 1'b1;
          state_nxt  = S_LOAD_B;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_LOAD_B: begin
        cmd.load_b = 1'b1;
        state_nxt  = S_NORM_B;
      end
      S_NORM_B: begin
        if (sts.norm_done) begin
          cmd.save_b = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_MUL;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.c_zero) begin
          cmd.set_degen = 1'b1;
          comp_nxt      = 2'd0;
          state_nxt     = S_EMIT;
        end else begin
          cmd.load_c = 1'b1;
          state_nxt  = S_NORM_C;
        end
      end
      S_NORM_C: begin
        if (sts.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_ITER)) begin
          cnt_nxt   = '0;
          comp_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_LAST)) begin
          cnt_nxt = '0;
          if (comp_r == 2'd2) begin
            comp_nxt  = 2'd0;
            state_nxt = S_EMIT;
          end else begin
            comp_nxt = comp_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          if (comp_r == 2'd2) begin
            comp_nxt  = 2'd0;
            state_nxt = S_IDLE;
          end else begin
            comp_nxt = comp_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      comp_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(comp_r)))
    else $error("stalled word moved");
  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (cnt_r <= CNT_W'(SQRT_ITER)))
    else $error("root counter overran");
  a_div_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (comp_r != 2'd3))
    else $error("bad divide component");
`endif

endmodule

FILE: src/ftng_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftng_dp
// datapath: vertex store, block scaling, shared multiplier, root and divider
// ----------------------------------------------------------------------------
module ftng_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [143:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic           cfg_wdata,
  input  ftng_pkg::cmd_t cmd,
  output ftng_pkg::status_t sts,
  output logic [143:0]   out_tdata,
  output logic           out_tuser,
  output logic           out_tlast
);
  import ftng_pkg::*;

  logic flip_r, calc_cfg_r, sticky_r, tri_calc_r, degen_r;
  logic [1:0] count_r;

  logic [POS_W-1:0]       held_p_r [3][3];
  logic [NRM_W-1:0]       held_n_r [3][3];
  logic [63:0]            v_mag_r  [3];
  logic                   v_neg_r  [3];
  logic [30:0]            a_mag_r  [3];
  logic                   a_neg_r  [3];
  logic [30:0]            b_mag_r  [3];
  logic                   b_neg_r  [3];
  logic [61:0]            prod_r;
  logic                   prod_neg_r;
  logic signed [63:0]     c_r      [3];
  logic [63:0]            s_r, sq_n_r, res_r, bit_r;
  logic [31:0]            rem_r;
  logic [Q_W-1:0]         num_r, q_r;
  logic signed [NRM_W-1:0] fn_r    [3];

  // input decode
  logic       has, ps, sticky_new;
  logic [1:0] idx;
  assign has        = in_tuser[0];
  assign ps         = in_tuser[1];
  assign idx        = ps ? 2'd0 : count_r;
  assign sticky_new = !has || (ps ? calc_cfg_r : sticky_r);

  // block scaling status
  logic any_hi, any_30, all_zero;
  always_comb begin
    any_hi   = 1'b0;
    any_30   = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi | (|v_mag_r[i][63:31]);
      any_30   = any_30 | v_mag_r[i][30];
      all_zero = all_zero & (v_mag_r[i] == '0);
    end
  end

  assign sts.third     = (idx == 2'd2);
  assign sts.calc      = sticky_new;
  assign sts.norm_done = !any_hi && (any_30 || all_zero);
  assign sts.c_zero    = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);

  // shared multiplier operand select
  logic [30:0] opa, opb;
  logic        op_neg;
  logic [2:0]  t_mul;
  always_comb begin
    opa    = '0;
    opb    = '0;
    op_neg = 1'b0;
    if (cmd.sq) begin
      case (cmd.cnt[1:0])
        2'd0:    opa = v_mag_r[0][30:0];
        2'd1:    opa = v_mag_r[1][30:0];
        default: opa = v_mag_r[2][30:0];
      endcase
      opb = opa;
    end else begin
      case (cmd.cnt[2:0])
        3'd0: begin
          opa = a_mag_r[1]; opb = b_mag_r[2]; op_neg = a_neg_r[1] ^ b_neg_r[2];
        end
        3'd1: begin
          opa = a_mag_r[2]; opb = b_mag_r[1]; op_neg = a_neg_r[2] ^ b_neg_r[1];
        end
        3'd2: begin
          opa = a_mag_r[2]; opb = b_mag_r[0]; op_neg = a_neg_r[2] ^ b_neg_r[0];
        end
        3'd3: begin
          opa = a_mag_r[0]; opb = b_mag_r[2]; op_neg = a_neg_r[0] ^ b_neg_r[2];
        end
        3'd4: begin
          opa = a_mag_r[0]; opb = b_mag_r[1]; op_neg = a_neg_r[0] ^ b_neg_r[1];
        end
        default: begin
          opa = a_mag_r[1]; opb = b_mag_r[0]; op_neg = a_neg_r[1] ^ b_neg_r[0];
        end
      endcase
    end
  end
  assign t_mul = cmd.cnt[2:0] - 3'd1;

  logic signed [63:0] term;
  always_comb begin
    term = $signed({2'b00, prod_r});
    if (prod_neg_r ^ t_mul[0]) begin
      term = -term;
    end
  end

  // divider helpers
  logic [45:0] div_num;
  logic [32:0] div_t;
  logic        div_ge;
  logic [Q_W-1:0] q_cl;
  assign div_num = ({15'd0, v_mag_r[cmd.comp][30:0]} << NFRAC) + {15'd0, res_r[31:1]};
  assign div_t   = {rem_r, num_r[Q_W-1]};
  assign div_ge  = (div_t >= {1'b0, res_r[31:0]});
  assign q_cl    = (q_r > Q_W'(NORM_LIM)) ? Q_W'(NORM_LIM) : q_r;

  logic [63:0] sq_try;
  assign sq_try = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r     <= 1'b0;
      calc_cfg_r <= 1'b0;
      sticky_r   <= 1'b0;
      count_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FLIP) flip_r <= cfg_wdata;
        else                       calc_cfg_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        sticky_r <= sticky_new;
        count_r  <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < 3; i++) begin
        held_p_r[idx][i] <= in_tdata[i*POS_W +: POS_W];
        held_n_r[idx][i] <= has ? in_tdata[3*POS_W + i*NRM_W +: NRM_W] : '0;
      end
      if (idx == 2'd2) begin
        tri_calc_r <= sticky_new;
        degen_r    <= 1'b0;
      end
    end
    if (cmd.load_a || cmd.load_b) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [32:0] d;
        if (cmd.load_a) begin
          d = $signed({held_p_r[0][i][31], held_p_r[0][i]})
            - $signed({held_p_r[1][i][31], held_p_r[1][i]});
        end else begin
          d = $signed({held_p_r[1][i][31], held_p_r[1][i]})
            - $signed({held_p_r[2][i][31], held_p_r[2][i]});
        end
        v_neg_r[i] <= d[32];
        v_mag_r[i] <= {31'd0, d[32] ? 33'(-d) : 33'(d)};
      end
    end
    if (cmd.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        v_mag_r[i] <= any_hi ? (v_mag_r[i] >> 1) : (v_mag_r[i] << 1);
      end
    end
    if (cmd.save_a) begin
      for (int i = 0; i < 3; i++) begin
        a_mag_r[i] <= v_mag_r[i][30:0];
        a_neg_r[i] <= v_neg_r[i];
      end
    end
    if (cmd.save_b) begin
      for (int i = 0; i < 3; i++) begin
        b_mag_r[i] <= v_mag_r[i][30:0];
        b_neg_r[i] <= v_neg_r[i];
      end
    end
    if ((cmd.mul && cmd.cnt < CNT_W'(MUL_STEPS)) || (cmd.sq && cmd.cnt < CNT_W'(SQ_STEPS))) begin
      prod_r     <= opa * opb;
      prod_neg_r <= op_neg;
    end
    // accumulate the product of the previous step
    if (cmd.mul && cmd.cnt != '0) begin
      c_r[t_mul[2:1]] <= t_mul[0] ? c_r[t_mul[2:1]] + term : term;
    end
    if (cmd.sq && cmd.cnt != '0) begin
      s_r <= ((cmd.cnt == CNT_W'(1)) ? 64'd0 : s_r) + {2'b00, prod_r};
    end
    if (cmd.load_c) begin
      for (int i = 0; i < 3; i++) begin
        v_neg_r[i] <= c_r[i][63];
        v_mag_r[i] <= c_r[i][63] ? 64'(-c_r[i]) : 64'(c_r[i]);
      end
    end
    if (cmd.set_degen) begin
      degen_r <= 1'b1;
      for (int i = 0; i < 3; i++) fn_r[i] <= '0;
    end
    if (cmd.sqrt) begin
      if (cmd.cnt == '0) begin
        sq_n_r <= s_r;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
      end else begin
        if (sq_n_r >= sq_try) begin
          sq_n_r <= sq_n_r - sq_try;
          res_r  <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
    if (cmd.div) begin
      if (cmd.cnt == '0) begin
        rem_r <= {3'd0, div_num[45:Q_W]};
        num_r <= div_num[Q_W-1:0];
        q_r   <= '0;
      end else if (cmd.cnt == CNT_W'(DIV_LAST)) begin
        fn_r[cmd.comp] <= v_neg_r[cmd.comp] ? -$signed(NRM_W'(q_cl))
                                            : $signed(NRM_W'(q_cl));
      end else begin
        rem_r <= div_ge ? 32'(div_t - {1'b0, res_r[31:0]}) : div_t[31:0];
        num_r <= num_r << 1;
        q_r   <= {q_r[Q_W-2:0], div_ge};
      end
    end
  end

  // corner output, selected by the emit index
  always_comb begin
    logic signed [NRM_W-1:0] n;
    logic signed [NRM_W-1:0] g;
    out_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      out_tdata[i*POS_W +: POS_W] = held_p_r[cmd.comp][i];
    end
    for (int i = 0; i < 3; i++) begin
      g = $signed(held_n_r[cmd.comp][i]);
      if (g > NORM_LIM)       g = NORM_LIM;
      else if (g < -NORM_LIM) g = -NORM_LIM;
      n = tri_calc_r ? fn_r[i] : g;
      out_tdata[3*POS_W + i*NRM_W +: NRM_W] = flip_r ? -n : n;
    end
  end
  assign out_tuser = degen_r;
  assign out_tlast = (cmd.comp == 2'd2);

endmodule

FILE: src/flat_triangle_normal_gen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_triangle_normal_gen_top
// flat-shaded triangle normal generator, three corners out per triangle
// ----------------------------------------------------------------------------
// in channel: one vertex word per handshake, in_tdata holds position and
// supplied normal, in_tuser holds has_normal and pass_start.
// out channel: three corner words per triangle, out_tlast on the third,
// out_tuser flags a zero-area face.
// cfg port: index 0 flips the normals, index 1 selects calculate mode.
// the first two vertices of a triangle are stored while the block stays ready.
// the third vertex in pass-through mode leads straight to the three corners,
// one per cycle while out_tready is high.
// in calculate mode the face normal is worked out first: a load step and
// block scaling for each edge, the cross product on the shared multiplier,
// a zero check, block scaling of the cross product, the sum of squares, an
// integer square root and the bit-serial divider for each of the three
// components, then the corners.
// a zero-area face goes from the zero check straight to the corners.
// in_tready is low from the third vertex until the last corner is taken;
// a stalled receiver holds the current corner word.
// reset (synchronous, rst_n low) clears both registers, the vertex count
// and the sticky calculate mode.
// ----------------------------------------------------------------------------
module flat_triangle_normal_gen_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,  // pos_x, pos_y, pos_z, given_nx, given_ny, given_nz
  input  logic [1:0]   in_tuser,  // has_normal, pass_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata, // out_x, out_y, out_z, norm_x, norm_y, norm_z
  output logic         out_tuser, // degenerate
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic         cfg_wdata
);
  import ftng_pkg::*;

  cmd_t    cmd;
  status_t sts;

  ftng_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ftng_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
